@@ rtl/core/vcmc_pkg.sv @@
// ----------------------------------------------------------------------------
// vcmc_pkg
// shared types, codes and helpers of the voice command mode controller
// ----------------------------------------------------------------------------
`default_nettype none

package vcmc_pkg;

    // lane count range
    localparam int unsigned LANE_MAX        = 8;
    localparam int unsigned NUM_CLASSES_DEF = 8;

    // field widths
    localparam int unsigned SCORE_W = 8;
    localparam int unsigned IDX_W   = 3;
    localparam int unsigned CODE_W  = 3;
    localparam int unsigned CNT_W   = 4;
    localparam int unsigned SPEED_W = 16;
    localparam int unsigned SINCE_W = 16;
    localparam int unsigned TIMER_W = 24;
    localparam int unsigned MAP_W   = 24;
    localparam int unsigned CFG_W   = 24;
    localparam int unsigned CFGI_W  = 3;
    localparam int unsigned IN_W    = 72;
    localparam int unsigned OUT_W   = 32;

    // command codes from the class map
    localparam logic [CODE_W-1:0] CMD_NONE     = 3'd0;
    localparam logic [CODE_W-1:0] CMD_ACTIVATE = 3'd1;
    localparam logic [CODE_W-1:0] CMD_UP       = 3'd2;
    localparam logic [CODE_W-1:0] CMD_DOWN     = 3'd3;
    localparam logic [CODE_W-1:0] CMD_STOP     = 3'd4;
    localparam logic [CODE_W-1:0] CMD_HELP     = 3'd5;

    // motion codes, both for the drive state in and the command out
    localparam logic [1:0] MOT_NONE = 2'd0;
    localparam logic [1:0] MOT_UP   = 2'd1;
    localparam logic [1:0] MOT_DOWN = 2'd2;
    localparam logic [1:0] MOT_STOP = 2'd3;

    // event codes
    localparam logic [2:0] EV_NOTHING   = 3'd0;
    localparam logic [2:0] EV_NO_WINNER = 3'd1;
    localparam logic [2:0] EV_UNMAPPED  = 3'd2;
    localparam logic [2:0] EV_COOLDOWN  = 3'd3;
    localparam logic [2:0] EV_TAKEN     = 3'd4;
    localparam logic [2:0] EV_TIMEOUT   = 3'd5;

    // register indexes
    localparam logic [CFGI_W-1:0] REG_THRESHOLD  = 3'd0;
    localparam logic [CFGI_W-1:0] REG_COOLDOWN   = 3'd1;
    localparam logic [CFGI_W-1:0] REG_INACTIVITY = 3'd2;
    localparam logic [CFGI_W-1:0] REG_STOP_TICKS = 3'd3;
    localparam logic [CFGI_W-1:0] REG_CLASS_MAP  = 3'd4;
    localparam logic [CFGI_W-1:0] REG_CLASS_CNT  = 3'd5;
    localparam logic [CFGI_W-1:0] REG_SPEED      = 3'd6;

    // one lane candidate: masked score, its index and its mapped command
    typedef struct packed {
        logic [SCORE_W-1:0] value;
        logic [IDX_W-1:0]   idx;
        logic [CODE_W-1:0]  cmd;
    } t_pick;

    typedef struct packed {
        logic [SCORE_W-1:0] threshold;
        logic [SINCE_W-1:0] cooldown;
        logic [TIMER_W-1:0] inactivity;
        logic [TIMER_W-1:0] stop_ticks;
        logic [MAP_W-1:0]   class_map;
        logic [CNT_W-1:0]   class_count;
        logic [SPEED_W-1:0] drive_speed;
    } t_cfg;

    // result fields, lowest field in the lowest bits
    typedef struct packed {
        logic [IDX_W-1:0]   best_class;
        logic [2:0]         event_res;
        logic               stopped;
        logic               active;
        logic [SPEED_W-1:0] speed;
        logic [1:0]         motion_cmd;
    } t_result;

    // larger score wins, left side keeps ties so the first maximum survives
    function automatic t_pick pick_max(input t_pick a, input t_pick b);
        return (b.value > a.value) ? b : a;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/vcmc_lane.sv @@
// ----------------------------------------------------------------------------
// vcmc_lane
// one score lane: gates the score by the lane count and looks up its command
// ----------------------------------------------------------------------------
`default_nettype none

module vcmc_lane #(
    parameter int unsigned LANE_IDX = 0
) (
    input  wire logic [vcmc_pkg::SCORE_W-1:0] i_score,
    input  wire logic [vcmc_pkg::CNT_W-1:0]   i_class_count,
    input  wire logic [vcmc_pkg::MAP_W-1:0]   i_class_map,
    output vcmc_pkg::t_pick                   o_pick
);
    import vcmc_pkg::*;

    logic in_use;

    // lane 0 is always in use, a zero count acts as one
    assign in_use = (LANE_IDX == 0) || (i_class_count > CNT_W'(LANE_IDX));

    assign o_pick.value = in_use ? i_score : '0;
    assign o_pick.idx   = IDX_W'(LANE_IDX);
    assign o_pick.cmd   = i_class_map[CODE_W*LANE_IDX +: CODE_W];

endmodule

`default_nettype wire

@@ rtl/core/vcmc_merge.sv @@
// ----------------------------------------------------------------------------
// vcmc_merge
// three-level compare tree over the lane candidates, first maximum wins
// ----------------------------------------------------------------------------
`default_nettype none

module vcmc_merge #(
    parameter int unsigned NUM_CLASSES = vcmc_pkg::NUM_CLASSES_DEF
) (
    input  wire vcmc_pkg::t_pick i_picks [NUM_CLASSES],
    output vcmc_pkg::t_pick      o_pick
);
    import vcmc_pkg::*;

    t_pick leaf [LANE_MAX];
    t_pick lvl1 [LANE_MAX/2];
    t_pick lvl2 [LANE_MAX/4];

    // unused leaves sit on the right with zero score and never win
    always_comb begin
        for (int k = 0; k < LANE_MAX; k++) begin
            if (k < NUM_CLASSES) begin
                leaf[k] = i_picks[k];
            end else begin
                leaf[k] = '0;
            end
        end
        for (int k = 0; k < LANE_MAX/2; k++) begin
            lvl1[k] = pick_max(leaf[2*k], leaf[2*k+1]);
        end
        for (int k = 0; k < LANE_MAX/4; k++) begin
            lvl2[k] = pick_max(lvl1[2*k], lvl1[2*k+1]);
        end
    end

    assign o_pick = pick_max(lvl2[0], lvl2[1]);

endmodule

`default_nettype wire

@@ rtl/core/vcmc_mode.sv @@
// ----------------------------------------------------------------------------
// vcmc_mode
// command filter and inactive/active mode machine with timeout and cooldown
// ----------------------------------------------------------------------------
`default_nettype none

module vcmc_mode (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_take,
    input  wire logic                  i_is_result,
    input  wire vcmc_pkg::t_pick       i_pick,
    input  wire logic [1:0]            i_motion,
    input  wire vcmc_pkg::t_cfg        i_cfg,
    output vcmc_pkg::t_result          o_res
);
    import vcmc_pkg::*;

    logic               r_mode_active, n_mode_active;
    logic               r_stop_flag,   n_stop_flag;
    logic [TIMER_W-1:0] r_timer,       n_timer;
    logic [SINCE_W-1:0] r_since,       n_since;

    logic [TIMER_W-1:0] arm_inact;
    logic [TIMER_W-1:0] arm_stop;

    // arming with zero gives one tick
    assign arm_inact = (i_cfg.inactivity == '0) ? TIMER_W'(1) : i_cfg.inactivity;
    assign arm_stop  = (i_cfg.stop_ticks == '0) ? TIMER_W'(1) : i_cfg.stop_ticks;

    always_comb begin
        n_mode_active    = r_mode_active;
        n_stop_flag      = r_stop_flag;
        n_timer          = r_timer;
        n_since          = r_since;
        o_res.motion_cmd = MOT_NONE;
        o_res.speed      = '0;
        o_res.event_res  = EV_NOTHING;
        o_res.best_class = '0;

        if (!i_is_result) begin
            // tick
            if (r_since != '1) begin
                n_since = r_since + SINCE_W'(1);
            end
            if (r_timer != '0) begin
                n_timer = r_timer - TIMER_W'(1);
                if (r_timer == TIMER_W'(1)) begin
                    n_mode_active    = 1'b0;
                    n_stop_flag      = 1'b0;
                    o_res.motion_cmd = MOT_STOP;
                    o_res.event_res  = EV_TIMEOUT;
                end
            end
        end else begin
            o_res.best_class = i_pick.idx;
            if (i_pick.value == '0 || i_pick.value < i_cfg.threshold) begin
                o_res.event_res = EV_NO_WINNER;
            end else if (i_pick.cmd == CMD_NONE || i_pick.cmd > CMD_HELP) begin
                o_res.event_res = EV_UNMAPPED;
            end else if (r_since < i_cfg.cooldown) begin
                o_res.event_res = EV_COOLDOWN;
            end else begin
                o_res.event_res = EV_TAKEN;
                n_since         = '0;
                unique case (i_pick.cmd)
                    CMD_ACTIVATE: begin
                        if (!r_mode_active) begin
                            n_mode_active = 1'b1;
                            n_stop_flag   = 1'b0;
                            n_timer       = arm_inact;
                        end
                    end
                    CMD_UP: begin
                        if (r_mode_active && i_motion != MOT_UP) begin
                            o_res.motion_cmd = MOT_UP;
                            o_res.speed      = i_cfg.drive_speed;
                            n_stop_flag      = 1'b0;
                            n_timer          = arm_inact;
                        end
                    end
                    CMD_DOWN: begin
                        if (r_mode_active && i_motion != MOT_DOWN) begin
                            o_res.motion_cmd = MOT_DOWN;
                            o_res.speed      = i_cfg.drive_speed;
                            n_stop_flag      = 1'b0;
                            n_timer          = arm_inact;
                        end
                    end
                    CMD_STOP: begin
                        if (r_mode_active) begin
                            o_res.motion_cmd = MOT_STOP;
                            n_stop_flag      = 1'b1;
                            n_timer          = arm_stop;
                        end
                    end
                    default: begin
                        // help
                        o_res.motion_cmd = MOT_STOP;
                        n_mode_active    = 1'b0;
                        n_stop_flag      = 1'b0;
                        n_timer          = '0;
                    end
                endcase
            end
        end

        o_res.active  = n_mode_active;
        o_res.stopped = n_stop_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_active <= 1'b0;
            r_stop_flag   <= 1'b0;
            r_timer       <= '0;
            r_since       <= '0;
        end else if (i_take) begin
            r_mode_active <= n_mode_active;
            r_stop_flag   <= n_stop_flag;
            r_timer       <= n_timer;
            r_since       <= n_since;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/voice_command_mode_controller_top.sv @@
// ----------------------------------------------------------------------------
// voice_command_mode_controller_top
// voice command filter and mode controller with score lanes and merge tree
// ----------------------------------------------------------------------------
// usage
// - input stream s_axis: one item is either a 1 ms tick (tuser 0) or a
//   classifier result (tuser 1) carrying eight scores and the drive state
// - output stream m_axis: exactly one result item per input item, in order
// - config channel: index/data writes, always ready; write only while no
//   item is in flight
// - every item is worked combinationally: the lanes, the three-level compare
//   tree and the mode machine sit between the state registers and the
//   output register, so m_axis_tvalid rises in the cycle after the accept
// - throughput is one item per cycle; a new item is taken while the output
//   register is empty or being drained in the same cycle
// - when the receiver stalls the output register holds its item and the
//   input stalls as well, nothing is dropped
// - reset puts the registers at their defaults, the mode inactive, the
//   timer disarmed, the cooldown count at zero and the output empty
// ----------------------------------------------------------------------------
`default_nettype none

module voice_command_mode_controller_top #(
    parameter int unsigned NUM_CLASSES = vcmc_pkg::NUM_CLASSES_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,

    // score_0..score_7 [63:0], motion_state [65:64], zero pad [71:66]
    input  wire logic [vcmc_pkg::IN_W-1:0]   s_axis_tdata,
    // opcode [0]
    input  wire logic [0:0]                  s_axis_tuser,
    input  wire logic                        s_axis_tvalid,
    output      logic                        s_axis_tready,

    // motion_cmd [1:0], speed [17:2], active [18], stopped [19],
    // event_res [22:20], best_class [25:23], zero pad [31:26]
    output      logic [vcmc_pkg::OUT_W-1:0]  m_axis_tdata,
    output      logic                        m_axis_tvalid,
    input  wire logic                        m_axis_tready,

    input  wire logic                        i_cfg_valid,
    output      logic                        o_cfg_ready,
    input  wire logic [vcmc_pkg::CFGI_W-1:0] i_cfg_index,
    input  wire logic [vcmc_pkg::CFG_W-1:0]  i_cfg_data
);
    import vcmc_pkg::*;

    t_cfg    r_cfg;
    t_pick   lane_picks [NUM_CLASSES];
    t_pick   win;
    t_result res;
    t_result r_out;
    logic    r_out_valid;
    logic    take;

    // ---------------- configuration registers ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold   <= SCORE_W'(217);
            r_cfg.cooldown    <= SINCE_W'(1000);
            r_cfg.inactivity  <= TIMER_W'(10000);
            r_cfg.stop_ticks  <= TIMER_W'(5000);
            r_cfg.class_map   <= '0;
            r_cfg.class_count <= CNT_W'(8);
            r_cfg.drive_speed <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_THRESHOLD:  r_cfg.threshold   <= i_cfg_data[SCORE_W-1:0];
                REG_COOLDOWN:   r_cfg.cooldown    <= i_cfg_data[SINCE_W-1:0];
                REG_INACTIVITY: r_cfg.inactivity  <= i_cfg_data[TIMER_W-1:0];
                REG_STOP_TICKS: r_cfg.stop_ticks  <= i_cfg_data[TIMER_W-1:0];
                REG_CLASS_MAP:  r_cfg.class_map   <= i_cfg_data[MAP_W-1:0];
                REG_CLASS_CNT:  r_cfg.class_count <= i_cfg_data[CNT_W-1:0];
                REG_SPEED:      r_cfg.drive_speed <= i_cfg_data[SPEED_W-1:0];
                default: begin
                    // index beyond the register list is ignored
                end
            endcase
        end
    end

    // ---------------- handshake ----------------
    // take an item whenever the output slot is free or empties this cycle
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign take          = s_axis_tvalid && s_axis_tready;

    // ---------------- score lanes ----------------
    for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_lane
        vcmc_lane #(
            .LANE_IDX (g)
        ) u_lane (
            .i_score       (s_axis_tdata[SCORE_W*g +: SCORE_W]),
            .i_class_count (r_cfg.class_count),
            .i_class_map   (r_cfg.class_map),
            .o_pick        (lane_picks[g])
        );
    end

    // ---------------- merge tree ----------------
    vcmc_merge #(
        .NUM_CLASSES (NUM_CLASSES)
    ) u_merge (
        .i_picks (lane_picks),
        .o_pick  (win)
    );

    // ---------------- mode machine ----------------
    vcmc_mode u_mode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_is_result (s_axis_tuser[0]),
        .i_pick      (win),
        .i_motion    (s_axis_tdata[SCORE_W*LANE_MAX +: 2]),
        .i_cfg       (r_cfg),
        .o_res       (res)
    );

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'(r_out);

`ifndef SYNTHESIS
    // a timeout always leaves the block inactive with a stop issued
    a_timeout_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_out.event_res == EV_TIMEOUT)
            |-> (!r_out.active && r_out.motion_cmd == MOT_STOP))
        else $error("timeout item not inactive with stop");

    // speed only rides along with a move command
    a_speed_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_out.speed != '0)
            |-> (r_out.motion_cmd == MOT_UP || r_out.motion_cmd == MOT_DOWN))
        else $error("speed reported without move command");

    // stop flag is only kept while active
    a_stopped_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_out.stopped) |-> r_out.active)
        else $error("stopped reported while inactive");

    // a move command is only issued on a taken command
    a_move_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (r_out.motion_cmd == MOT_UP || r_out.motion_cmd == MOT_DOWN))
            |-> (r_out.event_res == EV_TAKEN && r_out.active))
        else $error("move command without taken command");
`endif

endmodule

`default_nettype wire

@@ tb/sv/vcmc_tb_pkg.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vcmc_tb_pkg
// codes shared by the stimulus and the checker of the mode controller bench
// ----------------------------------------------------------------------------
package vcmc_tb_pkg;

    // opcode carried in s_axis_tuser
    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_RESULT = 1'b1;

    // register index with no register behind it
    localparam logic [2:0] REG_SPARE = 3'd7;

    // class map codes outside the command range
    localparam logic [2:0] MAP_RSVD_6 = 3'd6;
    localparam logic [2:0] MAP_RSVD_7 = 3'd7;

endpackage

@@ tb/sv/vcmc_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vcmc_checker
// watches the item, result and register channels of the mode controller,
// predicts every result item from its own copy of state and registers and
// compares them in order
// ----------------------------------------------------------------------------
module vcmc_checker #(
    parameter int unsigned LANES = vcmc_pkg::NUM_CLASSES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [vcmc_pkg::IN_W-1:0]   i_s_tdata,
    input  logic [0:0]                  i_s_tuser,
    input  logic                        i_s_tvalid,
    input  logic                        i_s_tready,
    input  logic [vcmc_pkg::OUT_W-1:0]  i_m_tdata,
    input  logic                        i_m_tvalid,
    input  logic                        i_m_tready,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic [vcmc_pkg::CFGI_W-1:0] i_cfg_index,
    input  logic [vcmc_pkg::CFG_W-1:0]  i_cfg_data,
    output int                          o_fail_count,
    output int                          o_results_seen,
    output int                          o_taken_count,
    output int                          o_timeout_count
);
    import vcmc_pkg::*;
    import vcmc_tb_pkg::*;

    localparam int RES_W = $bits(t_result);

    // register copies
    logic [SCORE_W-1:0] thr_r;
    logic [SINCE_W-1:0] cooldown_r;
    logic [TIMER_W-1:0] inact_r;
    logic [TIMER_W-1:0] stop_r;
    logic [MAP_W-1:0]   map_r;
    logic [CNT_W-1:0]   count_r;
    logic [SPEED_W-1:0] speed_r;

    // mode machine copy
    logic               mode_on;
    logic               halted;
    logic [TIMER_W-1:0] ticks_left;
    logic [SINCE_W-1:0] since_cmd;

    t_result            cmd_outputs_q[$];
    int                 mismatches;

    assign o_fail_count = mismatches;

    function automatic logic [TIMER_W-1:0] arm_value(input logic [TIMER_W-1:0] v);
        return (v == '0) ? TIMER_W'(1) : v;
    endfunction

    task automatic decide_command(input logic op, input logic [63:0] sc,
                                  input logic [1:0] mo, output t_result r);
        int                 lanes;
        int                 i;
        logic [SCORE_W-1:0] top_val;
        logic [IDX_W-1:0]   win;
        logic               found;
        logic [CODE_W-1:0]  code;
        r = '0;
        r.motion_cmd = MOT_NONE;
        r.event_res  = EV_NOTHING;
        if (op == OP_TICK) begin
            if (since_cmd != '1)
                since_cmd = since_cmd + SINCE_W'(1);
            if (ticks_left != '0) begin
                ticks_left = ticks_left - TIMER_W'(1);
                if (ticks_left == '0) begin
                    mode_on      = 1'b0;
                    halted       = 1'b0;
                    r.motion_cmd = MOT_STOP;
                    r.event_res  = EV_TIMEOUT;
                end
            end
        end else begin
            lanes = (count_r == 0) ? 1 : ((count_r > LANES) ? LANES : count_r);
            if (lanes > LANE_MAX)
                lanes = LANE_MAX;
            top_val = '0;
            win     = '0;
            found   = 1'b0;
            for (i = 0; i < LANE_MAX; i++) begin
                if (i < lanes && sc[8*i +: 8] > top_val) begin
                    top_val = sc[8*i +: 8];
                    win     = IDX_W'(i);
                    found   = 1'b1;
                end
            end
            code = map_r[3*win +: 3];
            if (!found || top_val < thr_r) begin
                r.event_res = EV_NO_WINNER;
            end else if (code == CMD_NONE || code > CMD_HELP) begin
                r.event_res = EV_UNMAPPED;
            end else if (since_cmd < cooldown_r) begin
                r.event_res = EV_COOLDOWN;
            end else begin
                r.event_res = EV_TAKEN;
                since_cmd   = '0;
                case (code)
                    CMD_ACTIVATE: begin
                        if (!mode_on) begin
                            mode_on    = 1'b1;
                            halted     = 1'b0;
                            ticks_left = arm_value(inact_r);
                        end
                    end
                    CMD_UP: begin
                        if (mode_on && mo != MOT_UP) begin
                            r.motion_cmd = MOT_UP;
                            r.speed      = speed_r;
                            halted       = 1'b0;
                            ticks_left   = arm_value(inact_r);
                        end
                    end
                    CMD_DOWN: begin
                        if (mode_on && mo != MOT_DOWN) begin
                            r.motion_cmd = MOT_DOWN;
                            r.speed      = speed_r;
                            halted       = 1'b0;
                            ticks_left   = arm_value(inact_r);
                        end
                    end
                    CMD_STOP: begin
                        if (mode_on) begin
                            r.motion_cmd = MOT_STOP;
                            halted       = 1'b1;
                            ticks_left   = arm_value(stop_r);
                        end
                    end
                    default: begin
                        // help
                        r.motion_cmd = MOT_STOP;
                        mode_on      = 1'b0;
                        halted       = 1'b0;
                        ticks_left   = '0;
                    end
                endcase
            end
            r.best_class = win;
        end
        r.active  = mode_on;
        r.stopped = halted;
    endtask

    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        t_result next_out;
        logic    bad;
        if (!i_rst_n) begin
            thr_r      = 8'd217;
            cooldown_r = 16'd1000;
            inact_r    = 24'd10000;
            stop_r     = 24'd5000;
            map_r      = '0;
            count_r    = 4'd8;
            speed_r    = '0;
            mode_on    = 1'b0;
            halted     = 1'b0;
            ticks_left = '0;
            since_cmd  = '0;
            mismatches = 0;
            cmd_outputs_q.delete();
            o_results_seen  <= 0;
            o_taken_count   <= 0;
            o_timeout_count <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_THRESHOLD:  thr_r      = i_cfg_data[SCORE_W-1:0];
                    REG_COOLDOWN:   cooldown_r = i_cfg_data[SINCE_W-1:0];
                    REG_INACTIVITY: inact_r    = i_cfg_data[TIMER_W-1:0];
                    REG_STOP_TICKS: stop_r     = i_cfg_data[TIMER_W-1:0];
                    REG_CLASS_MAP:  map_r      = i_cfg_data[MAP_W-1:0];
                    REG_CLASS_CNT:  count_r    = i_cfg_data[CNT_W-1:0];
                    REG_SPEED:      speed_r    = i_cfg_data[SPEED_W-1:0];
                    default: ;
                endcase
            end
            // a result leaves in the cycle after its item at the earliest, so
            // it is matched before this edge's item is predicted
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[RES_W-1:0];
                o_results_seen <= o_results_seen + 1;
                if (cmd_outputs_q.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("%0t: result item with nothing expected: %h",
                                 $realtime, i_m_tdata);
                end else begin
                    want = cmd_outputs_q.pop_front();
                    bad  = (got.motion_cmd !== want.motion_cmd) ||
                           (got.speed      !== want.speed)      ||
                           (got.active     !== want.active)     ||
                           (got.stopped    !== want.stopped)    ||
                           (got.event_res  !== want.event_res)  ||
                           (got.best_class !== want.best_class) ||
                           (i_m_tdata[OUT_W-1:RES_W] !== '0);
                    if (bad) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display({"%0t: mismatch exp cmd=%0d spd=%h act=%0d stp=%0d",
                                      " ev=%0d best=%0d | got cmd=%0d spd=%h act=%0d",
                                      " stp=%0d ev=%0d best=%0d pad=%h"},
                                     $realtime, want.motion_cmd, want.speed,
                                     want.active, want.stopped, want.event_res,
                                     want.best_class, got.motion_cmd, got.speed,
                                     got.active, got.stopped, got.event_res,
                                     got.best_class, i_m_tdata[OUT_W-1:RES_W]);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                decide_command(i_s_tuser[0], i_s_tdata[63:0], i_s_tdata[65:64], next_out);
                cmd_outputs_q.push_back(next_out);
                if (next_out.event_res == EV_TAKEN)
                    o_taken_count <= o_taken_count + 1;
                if (next_out.event_res == EV_TIMEOUT)
                    o_timeout_count <= o_timeout_count + 1;
            end
        end
    end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the voice command mode controller: a short
// directed walk through the mode machine, then six register settings with
// random ticks and score items under changing idle and stall patterns
// ----------------------------------------------------------------------------
module tb_top;
    import vcmc_pkg::*;
    import vcmc_tb_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;

    // clock, reset and block inputs, all known from time zero
    logic               i_clk     = 1'b0;
    logic               i_rst_n   = 1'b0;
    logic [IN_W-1:0]    s_tdata   = '0;
    logic [0:0]         s_tuser   = '0;
    logic               s_tvalid  = 1'b0;
    wire                s_tready;
    wire  [OUT_W-1:0]   m_tdata;
    wire                m_tvalid;
    logic               m_tready  = 1'b0;
    logic               cfg_valid = 1'b0;
    wire                cfg_ready;
    logic [CFGI_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]   cfg_data  = '0;

    // idle shaping
    int                 src_idle_pct   = 0;
    int                 sink_stall_pct = 0;
    logic               hold_toggle    = 1'b0;
    logic               hold_seen      = 1'b0;
    int                 hold_left      = 0;

    // bookkeeping
    int                 items_sent = 0;
    int                 cycle_count = 0;
    logic [SCORE_W-1:0] cur_thr   = 8'd217;
    int                 cur_lanes = 8;

    int                 fail_count;
    int                 results_seen;
    int                 taken_count;
    int                 timeout_count;

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    voice_command_mode_controller_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    vcmc_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_tdata       (s_tdata),
        .i_s_tuser       (s_tuser),
        .i_s_tvalid      (s_tvalid),
        .i_s_tready      (s_tready),
        .i_m_tdata       (m_tdata),
        .i_m_tvalid      (m_tvalid),
        .i_m_tready      (m_tready),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_results_seen  (results_seen),
        .o_taken_count   (taken_count),
        .o_timeout_count (timeout_count)
    );

    // result side ready: random stalls, plus a long hold-off whenever the
    // stimulus flips hold_toggle, counted down here
    always @(posedge i_clk) begin
        if (hold_toggle != hold_seen) begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready  <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // run watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d of %0d results seen",
                     cycle_count, results_seen, items_sent);
            $display("== FAIL ==");
            $finish;
        end
    end

    // scores with a single lane set
    function automatic logic [63:0] one_lane(input int lane, input logic [7:0] val);
        logic [63:0] sc;
        sc = '0;
        sc[8*lane +: 8] = val;
        return sc;
    endfunction

    // mostly valid commands, a few unmapped codes, activate always reachable
    function automatic logic [MAP_W-1:0] random_map(input int lanes);
        logic [MAP_W-1:0] m;
        int               k;
        int               act_lane;
        m = '0;
        for (k = 0; k < LANE_MAX; k++) begin
            if ($urandom_range(99) < 85)
                m[3*k +: 3] = 3'($urandom_range(CMD_HELP, CMD_ACTIVATE));
            else
                m[3*k +: 3] = 3'($urandom_range(7));
        end
        act_lane = $urandom_range(lanes - 1);
        m[3*act_lane +: 3] = CMD_ACTIVATE;
        return m;
    endfunction

    // offer one item and wait for its handshake; valid stays high unless the
    // sender idles, so back-to-back items never lower and raise it in one step
    task automatic send_item(input logic op, input logic [63:0] sc, input logic [1:0] mo);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(IN_W-66){1'b0}}, mo, sc};
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        items_sent++;
    endtask

    // drop valid and wait until every result item has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (results_seen != items_sent)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // write all registers in index order, optionally the spare index too
    task automatic program_regs(input logic [CFG_W-1:0] thr, cool, inact, stopt,
                                input logic [CFG_W-1:0] map, cnt, spd, input bit spare);
        logic [CFG_W-1:0] vals [0:7];
        int               n;
        int               k;
        vals[REG_THRESHOLD]  = thr;
        vals[REG_COOLDOWN]   = cool;
        vals[REG_INACTIVITY] = inact;
        vals[REG_STOP_TICKS] = stopt;
        vals[REG_CLASS_MAP]  = map;
        vals[REG_CLASS_CNT]  = cnt;
        vals[REG_SPEED]      = spd;
        vals[REG_SPARE]      = CFG_W'($urandom);
        n = spare ? 8 : 7;
        for (k = 0; k < n; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= CFGI_W'(k);
            cfg_data  <= vals[k];
            @(posedge i_clk);
            while (!cfg_ready)
                @(posedge i_clk);
        end
        cfg_valid <= 1'b0;
        cur_thr   = thr[SCORE_W-1:0];
        cur_lanes = (cnt[CNT_W-1:0] == 0) ? 1 :
                    ((cnt[CNT_W-1:0] > LANE_MAX) ? LANE_MAX : cnt[CNT_W-1:0]);
    endtask

    // one random item: ticks, well-formed winning scores, and noise
    task automatic send_random();
        logic [63:0] sc;
        logic [7:0]  wv;
        int          pick;
        int          w;
        int          k;
        pick = $urandom_range(99);
        sc   = {$urandom, $urandom};
        if (pick < 40) begin
            // tick, data bits are don't-care to the block
            send_item(OP_TICK, sc, 2'($urandom_range(3)));
        end else begin
            if (pick < 85) begin
                // clear winner at or above threshold, lanes past the count random
                w  = $urandom_range(cur_lanes - 1);
                wv = 8'($urandom_range(255, cur_thr));
                for (k = 0; k < cur_lanes; k++)
                    sc[8*k +: 8] = (wv == 0) ? 8'd0 : 8'($urandom_range(wv - 1));
                sc[8*w +: 8] = wv;
                // occasional tie with a later lane, first one must win
                if ($urandom_range(9) == 0 && w + 1 < cur_lanes)
                    sc[8*(w+1) +: 8] = wv;
            end else if (pick < 90) begin
                sc = '0;
            end else if (pick < 95 && cur_thr != 0) begin
                for (k = 0; k < LANE_MAX; k++)
                    sc[8*k +: 8] = 8'($urandom_range(cur_thr - 1));
            end
            send_item(OP_RESULT, sc, 2'($urandom_range(3)));
        end
    endtask

    task automatic random_run(input int n);
        int k;
        for (k = 0; k < n; k++)
            send_random();
    endtask

    initial begin : stimulus
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults: threshold 217, empty class map, long cooldown
        send_item(OP_TICK, '0, MOT_NONE);
        send_item(OP_RESULT, '0, MOT_NONE);
        send_item(OP_RESULT, '1, MOT_STOP);
        send_item(OP_RESULT, one_lane(3, 8'd216), MOT_NONE);
        drain();

        // one lane per command, lanes 5..7 unmapped, no cooldown, short timers
        program_regs(24'd200, 24'd0, 24'd3, 24'd2,
                     {CMD_NONE, MAP_RSVD_7, MAP_RSVD_6, CMD_HELP,
                      CMD_STOP, CMD_DOWN, CMD_UP, CMD_ACTIVATE},
                     24'd8, 24'h00FFFF, 1'b0);
        // up and stop while inactive are taken but do nothing
        send_item(OP_RESULT, one_lane(1, 8'd255), MOT_NONE);
        send_item(OP_RESULT, one_lane(3, 8'd255), MOT_NONE);
        // activate, then again while active
        send_item(OP_RESULT, one_lane(0, 8'd255), MOT_NONE);
        send_item(OP_RESULT, one_lane(0, 8'd255), MOT_NONE);
        // up already moving up, then from idle
        send_item(OP_RESULT, one_lane(1, 8'd255), MOT_UP);
        send_item(OP_RESULT, one_lane(1, 8'd255), MOT_NONE);
        // down already moving down, then from drive state three
        send_item(OP_RESULT, one_lane(2, 8'd255), MOT_DOWN);
        send_item(OP_RESULT, one_lane(2, 8'd255), MOT_STOP);
        // stop arms the two-tick stop timeout, which then expires
        send_item(OP_RESULT, one_lane(3, 8'd255), MOT_NONE);
        send_item(OP_TICK, '1, MOT_NONE);
        send_item(OP_TICK, '0, MOT_NONE);
        // unmapped codes six, seven and none
        send_item(OP_RESULT, one_lane(5, 8'd255), MOT_NONE);
        send_item(OP_RESULT, one_lane(6, 8'd255), MOT_NONE);
        send_item(OP_RESULT, one_lane(7, 8'd255), MOT_NONE);
        // help while active
        send_item(OP_RESULT, one_lane(0, 8'd255), MOT_NONE);
        send_item(OP_RESULT, one_lane(4, 8'd255), MOT_UP);
        // tie goes to the first lane, threshold edge both sides
        send_item(OP_RESULT, one_lane(1, 8'd230) | one_lane(3, 8'd230), MOT_NONE);
        send_item(OP_RESULT, one_lane(2, 8'd200), MOT_NONE);
        send_item(OP_RESULT, one_lane(2, 8'd199), MOT_NONE);
        drain();

        // no idling, with one long hold-off on the result side
        program_regs(24'd200, 24'd2, 24'd12, 24'd6, random_map(8), 24'd8,
                     CFG_W'($urandom_range(16'hFFFF)), 1'b0);
        src_idle_pct   = 0;
        sink_stall_pct <= 0;
        hold_toggle    <= ~hold_toggle;
        random_run(150);
        drain();

        // sender idle; zero timeouts arm one tick, count zero means one lane
        program_regs(24'd128, 24'd0, 24'd0, 24'd0, random_map(1), 24'd0,
                     24'd0, 1'b0);
        src_idle_pct   = 75;
        sink_stall_pct <= 0;
        random_run(150);
        drain();

        // receiver stalls; extremes with high write bits masked off, all
        // lanes unmapped, spare index written
        program_regs(24'hFFFF00, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                     24'hFFFFFF, CFG_W'($urandom), 1'b1);
        src_idle_pct   = 0;
        sink_stall_pct <= 75;
        random_run(80);
        drain();

        // both sides idle a little
        program_regs(CFG_W'($urandom_range(255)), 24'd3, 24'd20, 24'd8, random_map(5),
                     24'd5, CFG_W'($urandom_range(16'hFFFF)), 1'b0);
        src_idle_pct   = 19;
        sink_stall_pct <= 19;
        random_run(180);
        drain();

        // receiver stalls with a long hold-off while the sender keeps
        // offering, so the output fills and the input backs up
        program_regs(24'd180, 24'd1, 24'd9, 24'd4, random_map(8), 24'd12,
                     CFG_W'($urandom_range(16'hFFFF)), 1'b0);
        src_idle_pct   = 0;
        sink_stall_pct <= 75;
        hold_toggle    <= ~hold_toggle;
        random_run(180);
        drain();

        // one lane, full threshold, one-tick timeouts, full speed
        program_regs(24'd255, 24'd0, 24'd1, 24'd1, random_map(1), 24'd1,
                     24'h00FFFF, 1'b0);
        src_idle_pct   = 0;
        sink_stall_pct <= 0;
        random_run(110);
        drain();

        repeat (5) @(posedge i_clk);
        $display("ran %0d items over a directed walk and six register settings,",
                 items_sent);
        $display("with idle, stall and hold-off stretches: %0d commands taken, %0d timeouts",
                 taken_count, timeout_count);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
